// File: src/osph_pkg.sv
// Package with shared types and constants for the octahedron sphere triangle generator.
package osph_pkg;

    // Deepest subdivision level and fraction bits of a coordinate.
    localparam int MAX_LEVEL = 6;
    localparam int FRAC_BITS = 14;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_SQR,
        ST_ROOT,
        ST_DIV,
        ST_NEXT,
        ST_EMIT
    } state_t;

    // Child selection codes of one subdivision step.
    localparam logic [1:0] CHILD_A   = 2'd0;
    localparam logic [1:0] CHILD_C   = 2'd1;
    localparam logic [1:0] CHILD_B   = 2'd2;
    localparam logic [1:0] CHILD_MID = 2'd3;

    // Base point number for each octahedron face corner.
    function automatic logic [2:0] face_point(input logic [2:0] face, input logic [1:0] k);
        logic [2:0] p;
        p = 3'd0;
        unique case (face)
            3'd0: p = (k == 2'd0) ? 3'd0 : (k == 2'd1) ? 3'd1 : 3'd2;
            3'd1: p = (k == 2'd0) ? 3'd0 : (k == 2'd1) ? 3'd2 : 3'd3;
            3'd2: p = (k == 2'd0) ? 3'd0 : (k == 2'd1) ? 3'd3 : 3'd4;
            3'd3: p = (k == 2'd0) ? 3'd0 : (k == 2'd1) ? 3'd4 : 3'd1;
            3'd4: p = (k == 2'd0) ? 3'd5 : (k == 2'd1) ? 3'd2 : 3'd1;
            3'd5: p = (k == 2'd0) ? 3'd5 : (k == 2'd1) ? 3'd3 : 3'd2;
            3'd6: p = (k == 2'd0) ? 3'd5 : (k == 2'd1) ? 3'd4 : 3'd3;
            default: p = (k == 2'd0) ? 3'd5 : (k == 2'd1) ? 3'd1 : 3'd4;
        endcase
        return p;
    endfunction

    // Sign code of one axis of a base point: 0 zero, 1 plus, 2 minus.
    function automatic logic [1:0] base_axis(input logic [2:0] p, input logic [1:0] ax);
        logic [1:0] r;
        r = 2'd0;
        unique case (p)
            3'd0: r = (ax == 2'd2) ? 2'd1 : 2'd0;
            3'd1: r = (ax == 2'd0) ? 2'd1 : 2'd0;
            3'd2: r = (ax == 2'd1) ? 2'd1 : 2'd0;
            3'd3: r = (ax == 2'd0) ? 2'd2 : 2'd0;
            3'd4: r = (ax == 2'd1) ? 2'd2 : 2'd0;
            default: r = (ax == 2'd2) ? 2'd2 : 2'd0;
        endcase
        return r;
    endfunction

endpackage

// File: src/octahedron_sphere_triangle_gen.sv
// Top level: maps a triangle index to three unit-sphere corners by serial subdivision.
// The first corner is ready once the bit-serial square, root and divide loops have run for
// every midpoint component at each level; an out-of-range index gives one flagged word.
// Throughput: one item at a time; the next word is taken once the sequencer is back in idle
// after the last corner leaves, so no new index is accepted while an item is in flight.
// Reset (aresetn, synchronous, active low) clears the sequencer and the level register.
module octahedron_sphere_triangle_gen (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [14:0]              s_triangle_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [15:0]       m_vertex_x,
    output logic signed [15:0]       m_vertex_y,
    output logic signed [15:0]       m_vertex_z,
    output logic [1:0]               m_corner,
    output logic                     m_last_corner,
    output logic                     m_index_out_of_range
);

    // Derived widths: coordinates, sums, squares and quotient.
    localparam int CW  = osph_pkg::FRAC_BITS + 2;          // signed coordinate
    localparam int MW  = osph_pkg::FRAC_BITS + 2;          // sum magnitude up to 2^(F+1)
    localparam int QW  = 2 * MW + 2;                       // sum of three squares
    localparam int RW  = QW / 2;                           // root width
    localparam int NW  = MW + osph_pkg::FRAC_BITS;         // dividend width
    localparam int SQC = $clog2(QW + 1);
    localparam int LVW = $clog2(osph_pkg::MAX_LEVEL + 1);
    localparam logic [LVW-1:0] MAXL = LVW'(osph_pkg::MAX_LEVEL);
    localparam logic [MW-1:0] ONE_M = MW'(1) << osph_pkg::FRAC_BITS;

    typedef logic signed [CW-1:0] coord_t;

    osph_pkg::state_t state_reg, state_next;

    // Level register.
    logic [2:0] level_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg <= 3'd0;
        end else if (cfg_we) begin
            level_reg <= cfg_wdata;
        end
    end

    logic [LVW-1:0] eff_level;
    always_comb begin
        if ({29'd0, level_reg} > osph_pkg::MAX_LEVEL) eff_level = MAXL;
        else eff_level = LVW'(level_reg);
    end

    // Working triangle, midpoints and item state.
    coord_t     tri_reg [3][3];
    coord_t     mid_reg [3][3];
    logic [14:0] idx_reg;
    logic [LVW-1:0] step_reg;      // remaining levels
    logic [1:0] mid_sel_reg;       // which midpoint: 0 ab, 1 ac, 2 cb
    logic [1:0] ax_reg;            // component counter
    logic [1:0] emit_reg;
    logic       oor_reg;
    logic [2:0] face_reg;

    // Sum magnitudes and signs of the current midpoint.
    logic [MW-1:0] smag_reg [3];
    logic          sneg_reg [3];

    // Serial squarer and accumulator: shift-add one bit per cycle.
    logic [QW-1:0]  acc_reg;
    logic [MW-1:0]  mplr_reg;
    logic [QW-1:0]  mcnd_reg;
    logic [SQC-1:0] cnt_reg;

    // Root: two bits of radicand per cycle.
    logic [QW-1:0]  rad_reg;
    logic [RW+1:0]  rem_reg;
    logic [RW-1:0]  root_reg;

    // Divider: restoring, one quotient bit per cycle.
    logic [NW-1:0]  dnum_reg;
    logic [RW:0]    drem_reg;
    logic [NW-1:0]  quo_reg;

    // Output register.
    logic           out_valid_reg;

    // Endpoints of the current midpoint.
    logic [1:0] pa, pb;
    always_comb begin
        unique case (mid_sel_reg)
            2'd0: begin pa = 2'd0; pb = 2'd1; end
            2'd1: begin pa = 2'd0; pb = 2'd2; end
            default: begin pa = 2'd2; pb = 2'd1; end
        endcase
    end

    logic signed [CW:0] sum_c;
    assign sum_c = {tri_reg[pa][ax_reg][CW-1], tri_reg[pa][ax_reg]}
                 + {tri_reg[pb][ax_reg][CW-1], tri_reg[pb][ax_reg]};

    // Root step.
    logic [RW+1:0] rtrial;
    logic [RW+1:0] rshift;
    assign rshift = {rem_reg[RW-1:0], rad_reg[QW-1 -: 2]};
    assign rtrial = {root_reg, 2'b01};

    // Divider step: the next dividend bit enters the partial remainder.
    logic [RW+1:0] dshift;
    assign dshift = {drem_reg, dnum_reg[NW-1]};

    logic [1:0] digit;
    assign digit = 2'(idx_reg >> (2 * (step_reg - LVW'(1))));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            osph_pkg::ST_IDLE: if (s_valid) state_next = osph_pkg::ST_LOAD;
            osph_pkg::ST_LOAD: begin
                if (oor_reg) state_next = osph_pkg::ST_EMIT;
                else if (step_reg == '0) state_next = osph_pkg::ST_EMIT;
                else state_next = osph_pkg::ST_SUM;
            end
            osph_pkg::ST_SUM: if (ax_reg == 2'd2) state_next = osph_pkg::ST_SQR;
            osph_pkg::ST_SQR:
                if (cnt_reg == SQC'(MW) && ax_reg == 2'd2) state_next = osph_pkg::ST_ROOT;
            osph_pkg::ST_ROOT: if (cnt_reg == SQC'(RW)) state_next = osph_pkg::ST_DIV;
            osph_pkg::ST_DIV:
                if (cnt_reg == SQC'(NW) && ax_reg == 2'd2) state_next = osph_pkg::ST_NEXT;
            osph_pkg::ST_NEXT: begin
                if (mid_sel_reg != 2'd2) state_next = osph_pkg::ST_SUM;
                else if (step_reg == LVW'(1)) state_next = osph_pkg::ST_EMIT;
                else state_next = osph_pkg::ST_SUM;
            end
            osph_pkg::ST_EMIT: begin
                if (m_ready && out_valid_reg && (oor_reg || emit_reg == 2'd2))
                    state_next = osph_pkg::ST_IDLE;
            end
            default: state_next = osph_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready = (state_reg == osph_pkg::ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= osph_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                osph_pkg::ST_IDLE: begin
                    out_valid_reg <= 1'b0;
                    if (s_valid) begin
                        idx_reg  <= s_triangle_index;
                        step_reg <= eff_level;
                        oor_reg  <= (s_triangle_index >> (2 * eff_level)) > 15'd7;
                        face_reg <= 3'(s_triangle_index >> (2 * eff_level));
                    end
                end
                osph_pkg::ST_LOAD: begin
                    // Fill the face triangle from the base points.
                    for (int k = 0; k < 3; k++) begin
                        for (int a = 0; a < 3; a++) begin
                            unique case (osph_pkg::base_axis(
                                    osph_pkg::face_point(face_reg, 2'(k)), 2'(a)))
                                2'd1: tri_reg[k][a] <= CW'(ONE_M);
                                2'd2: tri_reg[k][a] <= -CW'(ONE_M);
                                default: tri_reg[k][a] <= '0;
                            endcase
                        end
                    end
                    mid_sel_reg <= 2'd0;
                    ax_reg <= 2'd0;
                    emit_reg <= 2'd0;
                    out_valid_reg <= oor_reg || (step_reg == '0);
                end
                osph_pkg::ST_SUM: begin
                    smag_reg[ax_reg] <= sum_c[CW] ? MW'(-sum_c) : MW'(sum_c);
                    sneg_reg[ax_reg] <= sum_c[CW];
                    if (ax_reg == 2'd2) begin
                        ax_reg <= 2'd0;
                        acc_reg <= '0;
                        cnt_reg <= '0;
                        // component 2 is latched via smag_reg; restart from component 0
                        mplr_reg <= smag_reg[0];
                        mcnd_reg <= QW'(smag_reg[0]);
                    end else begin
                        ax_reg <= ax_reg + 2'd1;
                    end
                end
                osph_pkg::ST_SQR: begin
                    if (cnt_reg == SQC'(MW)) begin
                        cnt_reg <= '0;
                        if (ax_reg == 2'd2) begin
                            ax_reg <= 2'd0;
                            rad_reg <= acc_reg;
                            rem_reg <= '0;
                            root_reg <= '0;
                        end else begin
                            ax_reg <= ax_reg + 2'd1;
                            mplr_reg <= smag_reg[ax_reg + 2'd1];
                            mcnd_reg <= QW'(smag_reg[ax_reg + 2'd1]);
                        end
                    end else begin
                        if (mplr_reg[0]) acc_reg <= acc_reg + mcnd_reg;
                        mplr_reg <= mplr_reg >> 1;
                        mcnd_reg <= mcnd_reg << 1;
                        cnt_reg <= cnt_reg + SQC'(1);
                    end
                end
                osph_pkg::ST_ROOT: begin
                    if (cnt_reg == SQC'(RW)) begin
                        cnt_reg <= '0;
                        dnum_reg <= NW'({smag_reg[0], {osph_pkg::FRAC_BITS{1'b0}}});
                        drem_reg <= '0;
                        quo_reg <= '0;
                    end else begin
                        if (rshift >= rtrial) begin
                            rem_reg <= rshift - rtrial;
                            root_reg <= {root_reg[RW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rshift;
                            root_reg <= {root_reg[RW-2:0], 1'b0};
                        end
                        rad_reg <= rad_reg << 2;
                        cnt_reg <= cnt_reg + SQC'(1);
                    end
                end
                osph_pkg::ST_DIV: begin
                    if (cnt_reg == SQC'(NW)) begin
                        // Round to nearest: twice the remainder against the root.
                        logic [NW:0] qr;
                        logic [RW+1:0] twice;
                        logic [MW-1:0] qc;
                        twice = {drem_reg, 1'b0};
                        qr = {1'b0, quo_reg} +
                             ((root_reg != '0 && twice >=
                               (RW+2)'(root_reg) + (RW+2)'(root_reg[0])) ? (NW+1)'(1) : '0);
                        qc = (qr > (NW+1)'(ONE_M)) ? ONE_M : MW'(qr);
                        if (root_reg == '0) qc = '0;
                        mid_reg[mid_sel_reg][ax_reg] <=
                            sneg_reg[ax_reg] ? -CW'(qc) : CW'(qc);
                        cnt_reg <= '0;
                        if (ax_reg != 2'd2) begin
                            ax_reg <= ax_reg + 2'd1;
                            dnum_reg <= NW'({smag_reg[ax_reg + 2'd1],
                                             {osph_pkg::FRAC_BITS{1'b0}}});
                            drem_reg <= '0;
                            quo_reg <= '0;
                        end else begin
                            ax_reg <= 2'd0;
                        end
                    end else begin
                        if (dshift >= (RW+2)'(root_reg) && root_reg != '0) begin
                            drem_reg <= (RW+1)'(dshift - (RW+2)'(root_reg));
                            quo_reg <= {quo_reg[NW-2:0], 1'b1};
                        end else begin
                            drem_reg <= (RW+1)'(dshift);
                            quo_reg <= {quo_reg[NW-2:0], 1'b0};
                        end
                        dnum_reg <= dnum_reg << 1;
                        cnt_reg <= cnt_reg + SQC'(1);
                    end
                end
                osph_pkg::ST_NEXT: begin
                    if (mid_sel_reg != 2'd2) begin
                        mid_sel_reg <= mid_sel_reg + 2'd1;
                    end else begin
                        mid_sel_reg <= 2'd0;
                        step_reg <= step_reg - LVW'(1);
                        // Pick the child triangle; mid 0 ab, 1 ac, 2 cb.
                        for (int a = 0; a < 3; a++) begin
                            unique case (digit)
                                osph_pkg::CHILD_A: begin
                                    tri_reg[1][a] <= mid_reg[0][a];
                                    tri_reg[2][a] <= mid_reg[1][a];
                                end
                                osph_pkg::CHILD_C: begin
                                    tri_reg[0][a] <= tri_reg[2][a];
                                    tri_reg[1][a] <= mid_reg[1][a];
                                    tri_reg[2][a] <= mid_reg[2][a];
                                end
                                osph_pkg::CHILD_B: begin
                                    tri_reg[0][a] <= tri_reg[1][a];
                                    tri_reg[1][a] <= mid_reg[2][a];
                                    tri_reg[2][a] <= mid_reg[0][a];
                                end
                                default: begin
                                    tri_reg[0][a] <= mid_reg[2][a];
                                    tri_reg[1][a] <= mid_reg[1][a];
                                    tri_reg[2][a] <= mid_reg[0][a];
                                end
                            endcase
                        end
                        if (step_reg == LVW'(1)) out_valid_reg <= 1'b1;
                    end
                end
                osph_pkg::ST_EMIT: begin
                    if (m_ready && out_valid_reg) begin
                        if (oor_reg || emit_reg == 2'd2) out_valid_reg <= 1'b0;
                        else emit_reg <= emit_reg + 2'd1;
                    end
                end
                default: out_valid_reg <= 1'b0;
            endcase
        end
    end

    // Result word.
    assign m_valid = out_valid_reg && (state_reg == osph_pkg::ST_EMIT);
    assign m_vertex_x = oor_reg ? '0 : 16'(tri_reg[emit_reg][0]);
    assign m_vertex_y = oor_reg ? '0 : 16'(tri_reg[emit_reg][1]);
    assign m_vertex_z = oor_reg ? '0 : 16'(tri_reg[emit_reg][2]);
    assign m_corner = oor_reg ? 2'd0 : emit_reg;
    assign m_last_corner = oor_reg || (emit_reg == 2'd2);
    assign m_index_out_of_range = oor_reg;

endmodule

// File: src/osph_checker.sv
// Port checker for the triangle generator, bound to the top level.
module osph_port_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_corner,
    input logic        m_last_corner,
    input logic        m_index_out_of_range
);
    // No new word is taken while a result is pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken during output");
    // Out-of-range results are single and last.
    a_oor_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_index_out_of_range) |-> (m_last_corner && m_corner == 2'd0))
        else $error("out-of-range result malformed");
    // Last flag only on corner two for valid indexes.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_index_out_of_range) |-> (m_last_corner == (m_corner == 2'd2)))
        else $error("last flag wrong");
    // Corners advance in order after a taken word.
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_corner) |=> (m_valid && m_corner == $past(m_corner) + 2'd1))
        else $error("corner order broken");
endmodule

bind octahedron_sphere_triangle_gen osph_port_props u_osph_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_corner(m_corner),
    .m_last_corner(m_last_corner), .m_index_out_of_range(m_index_out_of_range)
);
